>>> rtl/core/ctr_pkg.sv
`default_nettype none
package ctr_pkg;

   localparam int CELL_COUNT = 60;
   localparam int CELL_IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   localparam int REQ_W = 16;
   localparam int RSP_W = 72;

   localparam logic KIND_STORE  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic REG_MODULE_NUMBER    = 1'b0;
   localparam logic REG_TRIP_TEMPERATURE = 1'b1;

   localparam logic        [7:0] MODULE_NUMBER_RESET = 8'd0;
   localparam logic signed [7:0] TRIP_RESET          = 8'sd60;

   localparam logic signed [7:0] LOW_CLAMP    = -8'sd40;
   localparam logic signed [7:0] HIGH_CLAMP   = 8'sd80;
   localparam logic        [7:0] CHECK_OFFSET = 8'd65;

   localparam logic signed [7:0] FAN_T_LO = 8'sd25;
   localparam logic signed [7:0] FAN_T_HI = 8'sd40;
   localparam logic        [7:0] FAN_IDLE = 8'd64;
   localparam logic        [7:0] FAN_S_LO = 8'd128;
   localparam logic        [7:0] FAN_S_HI = 8'd255;
   localparam int FAN_SPAN = int'(FAN_T_HI) - int'(FAN_T_LO);

   typedef struct packed {
      logic                  en;
      logic [CELL_IDX_W-1:0] addr;
   } tbl_rd_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scan_status_type;

   typedef struct packed {
      logic signed [7:0]     low;
      logic signed [7:0]     high;
      logic [CELL_IDX_W-1:0] low_idx;
      logic [CELL_IDX_W-1:0] high_idx;
   } scan_result_type;

   // Declared from the top bit down so that module_byte lands in the lowest bits.
   typedef struct packed {
      logic [3:0]        pad;
      logic              fan_valid;
      logic [7:0]        fan_speed;
      logic              relay_on;
      logic [7:0]        check_byte;
      logic [5:0]        low_cell;
      logic [5:0]        high_cell;
      logic [5:0]        enabled_count;
      logic signed [7:0] avg_temp;
      logic signed [7:0] high_temp;
      logic signed [7:0] low_temp;
      logic [7:0]        module_byte;
   } rsp_frame_type;

   // The ramp (high - 25) * 127 / 15 + 128 saturates for any step above 15, so only
   // steps 0..15 are computed. 127 * d / 15 is 8 * d + 7 * d / 15, and the last
   // quotient uses a reciprocal multiply that is exact for 7 * d up to 105.
   function automatic logic [7:0] fan_drive(input logic signed [7:0] high);
      logic [5:0]  d;
      logic [6:0]  y;
      logic [14:0] p;
      logic [7:0]  r;
      d = 6'(high - FAN_T_LO);
      y = 7'(d * 7);
      p = 15'(y * 137);
      if (high < FAN_T_LO) begin
         r = FAN_IDLE;
      end else if (int'(d) > FAN_SPAN) begin
         r = FAN_S_HI;
      end else begin
         r = 8'(int'(FAN_S_LO) + int'(d) * 8 + int'(p >> 11));
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/ctr_cell_table.sv
`default_nettype none
module ctr_cell_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [ctr_pkg::CELL_IDX_W-1:0] wr_addr,
   input  wire logic signed [7:0]             wr_data,
   input  wire ctr_pkg::tbl_rd_req_type       rd_req,
   output logic signed [7:0]                  rd_data
);
   import ctr_pkg::*;

   logic signed [7:0] mem_ff [CELL_COUNT];
   logic [CELL_COUNT-1:0] valid_ff;
   logic signed [7:0] rd_data_ff;

   // A cell that was never written reads as zero, which matches the cleared table.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_req.en) begin
         rd_data_ff <= valid_ff[rd_req.addr] ? mem_ff[rd_req.addr] : 8'sd0;
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> rtl/core/ctr_extremes_scan.sv
`default_nettype none
module ctr_extremes_scan (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      take,
   input  wire logic signed [7:0]         rd_data,
   output ctr_pkg::tbl_rd_req_type        rd_req,
   output ctr_pkg::scan_status_type       status,
   output ctr_pkg::scan_result_type       result
);
   import ctr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic [CELL_IDX_W-1:0] cnt_ff, cnt_in;
   scan_result_type res_ff, res_in;
   logic last;
   logic first;

   assign last  = (cnt_ff == CELL_IDX_W'(CELL_COUNT - 1));
   assign first = (cnt_ff == '0);

   always_comb begin
      rd_req.en   = 1'b0;
      rd_req.addr = '0;
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      res_in      = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rd_req.en = 1'b1;
               cnt_in    = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            // Data for cell cnt_ff is here; the read of the next cell goes out now.
            rd_req.en   = !last;
            rd_req.addr = cnt_ff + 1'b1;
            if (first || (rd_data < res_ff.low)) begin
               res_in.low     = rd_data;
               res_in.low_idx = cnt_ff;
            end
            if (first || (rd_data > res_ff.high)) begin
               res_in.high     = rd_data;
               res_in.high_idx = cnt_ff;
            end
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      res_ff <= res_in;
   end

   assign status.busy = (state_ff != S_IDLE);
   assign status.done = (state_ff == S_HOLD);
   assign result      = res_ff;
endmodule
`default_nettype wire

>>> rtl/core/ctr_frame_build.sv
`default_nettype none
module ctr_frame_build (
   input  wire ctr_pkg::scan_result_type scan,
   input  wire logic [7:0]              module_number,
   input  wire logic signed [7:0]       trip_temperature,
   output ctr_pkg::rsp_frame_type       frame
);
   import ctr_pkg::*;

   logic signed [7:0] low_c;
   logic signed [7:0] high_c;
   logic signed [8:0] sum_s;
   logic signed [8:0] adj_s;
   logic relay;

   always_comb begin
      low_c  = (scan.low < LOW_CLAMP) ? LOW_CLAMP : scan.low;
      high_c = (scan.high > HIGH_CLAMP) ? HIGH_CLAMP : scan.high;
      sum_s  = 9'(low_c) + 9'(high_c);
      // Adding one to a negative sum makes the halving round toward zero.
      adj_s  = sum_s + 9'(sum_s[8]);
      relay  = (high_c < trip_temperature);

      frame.pad           = '0;
      frame.module_byte   = module_number;
      frame.low_temp      = low_c;
      frame.high_temp     = high_c;
      frame.avg_temp      = adj_s[8:1];
      frame.enabled_count = 6'(CELL_COUNT - 1);
      frame.high_cell     = 6'(scan.high_idx);
      frame.low_cell      = 6'(scan.low_idx);
      frame.relay_on      = relay;
      frame.fan_valid     = relay;
      frame.fan_speed     = fan_drive(high_c);
      frame.check_byte    = module_number + 8'(low_c) + 8'(high_c) + 8'(adj_s[8:1])
                          + 8'(CELL_COUNT - 1) + 8'(scan.high_idx) + 8'(scan.low_idx)
                          + CHECK_OFFSET;
   end
endmodule
`default_nettype wire

>>> rtl/core/cell_temp_extremes_reporter.sv
// Cell temperature extremes reporter. A store transaction (tuser 0) writes one cell's
// signed temperature into a table of CELL_COUNT cells that reset clears to zero, and an
// index beyond the table is ignored. A report transaction (tuser 1) walks the table
// one cell per cycle through its single read port and one min/max compare unit;
// req_tready is low during the walk and stays low until the frame has moved into the
// output register. The result frame carries the clamped low and high temperatures
// with their first cell indices, the average, the checksum, and the relay and fan
// commands. A finished frame waits in the output register while further store
// transactions are taken.
`default_nettype none
module cell_temp_extremes_reporter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic                        req_tuser,  // kind
   // cell_index[5:0], temperature[13:6], zero pad[15:14]
   input  wire logic [ctr_pkg::REQ_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // module_byte[7:0], low_temp[15:8], high_temp[23:16], avg_temp[31:24],
   // enabled_count[37:32], high_cell[43:38], low_cell[49:44], check_byte[57:50],
   // relay_on[58], fan_speed[66:59], fan_valid[67], zero pad[71:68]
   output logic [ctr_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [7:0]                  csr_data
);
   import ctr_pkg::*;

   logic [7:0]        module_number_ff;
   logic signed [7:0] trip_ff;
   logic              rsp_valid_ff;
   rsp_frame_type     rsp_data_ff;

   logic [5:0]        req_cell;
   logic signed [7:0] req_temp;
   logic              req_accept;
   logic              store_en;
   logic              take;

   tbl_rd_req_type    rd_req;
   logic signed [7:0] rd_data;
   scan_status_type   status;
   scan_result_type   result;
   rsp_frame_type     frame;

   assign req_cell   = req_tdata[5:0];
   assign req_temp   = req_tdata[13:6];
   assign req_tready = !status.busy;
   assign req_accept = req_tvalid && req_tready;
   assign store_en   = req_accept && (req_tuser == KIND_STORE)
                    && ({1'b0, req_cell} < 7'(CELL_COUNT));
   assign take       = !rsp_valid_ff || rsp_tready;

   ctr_cell_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (store_en),
      .wr_addr (req_cell[CELL_IDX_W-1:0]),
      .wr_data (req_temp),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

   ctr_extremes_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept && (req_tuser == KIND_REPORT)),
      .take    (take),
      .rd_data (rd_data),
      .rd_req  (rd_req),
      .status  (status),
      .result  (result)
   );

   ctr_frame_build u_frame (
      .scan             (result),
      .module_number    (module_number_ff),
      .trip_temperature (trip_ff),
      .frame            (frame)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         module_number_ff <= MODULE_NUMBER_RESET;
         trip_ff          <= TRIP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODULE_NUMBER:    module_number_ff <= csr_data;
            REG_TRIP_TEMPERATURE: trip_ff          <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done && take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (status.done && take) begin
         rsp_data_ff <= frame;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
`default_nettype wire

>>> rtl/core/ctr_checker.sv
`default_nettype none
module ctr_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      req_tuser,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [ctr_pkg::RSP_W-1:0] rsp_tdata
);
   import ctr_pkg::*;

   // A pending result is not withdrawn before it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A store transaction never produces a result.
   a_store_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_STORE) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("store produced a result");

   // Once a report is accepted the table walk keeps the input closed.
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_REPORT) |=> !req_tready)
      else $error("input open during report walk");

   // The fan command is sent exactly when the relay stays on, and the pad is zero.
   a_frame_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[58] == rsp_tdata[67]) && (rsp_tdata[71:68] == 4'd0))
      else $error("inconsistent result frame flags");
endmodule

bind cell_temp_extremes_reporter ctr_checker u_ctr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

>>> verif/cell_temp_extremes_reporter_tb.sv
`default_nettype none
module cell_temp_extremes_reporter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctr_pkg::*;

   localparam int LOW_LIMIT      = -40;
   localparam int HIGH_LIMIT     = 80;
   localparam int CHECK_BIAS     = 65;
   localparam int FAN_ON_TEMP    = 25;
   localparam int FAN_FULL_TEMP  = 40;
   localparam int FAN_IDLE_SPEED = 64;
   localparam int FAN_MIN_SPEED  = 128;
   localparam int FAN_MAX_SPEED  = 255;
   localparam int SETTLE_CYCLES  = CELL_COUNT + 10;
   localparam int PHASE_ITEMS    = 380;

   typedef struct {
      logic              kind;
      logic [5:0]        cell_idx;
      logic signed [7:0] temp;
   } cell_cmd_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic                 req_tuser  = KIND_STORE;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic                 csr_index  = REG_MODULE_NUMBER;
   logic [7:0]           csr_data   = '0;

   // Mirror of the block's table and registers.
   logic signed [7:0]    cell_mirror [CELL_COUNT];
   logic [7:0]           module_number_q = MODULE_NUMBER_RESET;
   logic signed [7:0]    trip_q          = TRIP_RESET;

   cell_cmd_type         pending_cmds [$];
   cell_cmd_type         cmd_on_bus;
   rsp_frame_type        expected_frames [$];

   int                   req_idle_pct  = 0;
   int                   rsp_stall_pct = 0;
   int                   error_count   = 0;
   int                   stim_count    = 0;
   int                   band_lo       = -128;
   int                   band_hi       = 127;

   cell_temp_extremes_reporter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < CELL_COUNT; i++) begin
         cell_mirror[i] = '0;
      end
   end

   function automatic rsp_frame_type predict_report();
      rsp_frame_type f;
      int lo, hi, lo_at, hi_at, avg, fan, sum;
      lo = cell_mirror[0];
      hi = lo;
      lo_at = 0;
      hi_at = 0;
      // Strict compares keep the first index on ties.
      for (int i = 1; i < CELL_COUNT; i++) begin
         if (cell_mirror[i] < lo) begin
            lo = cell_mirror[i];
            lo_at = i;
         end
         if (cell_mirror[i] > hi) begin
            hi = cell_mirror[i];
            hi_at = i;
         end
      end
      if (lo < LOW_LIMIT) lo = LOW_LIMIT;
      if (hi > HIGH_LIMIT) hi = HIGH_LIMIT;
      avg = (lo + hi) / 2;
      if (hi < FAN_ON_TEMP) begin
         fan = FAN_IDLE_SPEED;
      end else begin
         fan = (hi - FAN_ON_TEMP) * (FAN_MAX_SPEED - FAN_MIN_SPEED)
               / (FAN_FULL_TEMP - FAN_ON_TEMP) + FAN_MIN_SPEED;
         if (fan > FAN_MAX_SPEED) fan = FAN_MAX_SPEED;
      end
      sum = int'(module_number_q) + (lo & 255) + (hi & 255) + (avg & 255)
            + ((CELL_COUNT - 1) & 63) + hi_at + lo_at + CHECK_BIAS;
      f = '0;
      f.module_byte   = module_number_q;
      f.low_temp      = 8'(lo);
      f.high_temp     = 8'(hi);
      f.avg_temp      = 8'(avg);
      f.enabled_count = 6'(CELL_COUNT - 1);
      f.high_cell     = 6'(hi_at);
      f.low_cell      = 6'(lo_at);
      f.check_byte    = 8'(sum);
      f.relay_on      = (hi < int'(trip_q));
      f.fan_speed     = 8'(fan);
      f.fan_valid     = f.relay_on;
      return f;
   endfunction

   function automatic void apply_cmd(input cell_cmd_type cmd);
      if (cmd.kind == KIND_STORE) begin
         if (cmd.cell_idx < CELL_COUNT) cell_mirror[cmd.cell_idx] = cmd.temp;
      end else begin
         expected_frames.push_back(predict_report());
      end
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] exp_v,
                              input logic signed [31:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         error_count++;
      end
   endtask

   task automatic check_frame(input rsp_frame_type got);
      rsp_frame_type want;
      if (expected_frames.size() == 0) begin
         $error("report frame arrived with none expected: %h", got);
         error_count++;
      end else begin
         want = expected_frames.pop_front();
         check_field("module_byte", want.module_byte, got.module_byte);
         check_field("low_temp", want.low_temp, got.low_temp);
         check_field("high_temp", want.high_temp, got.high_temp);
         check_field("avg_temp", want.avg_temp, got.avg_temp);
         check_field("enabled_count", want.enabled_count, got.enabled_count);
         check_field("high_cell", want.high_cell, got.high_cell);
         check_field("low_cell", want.low_cell, got.low_cell);
         check_field("check_byte", want.check_byte, got.check_byte);
         check_field("relay_on", want.relay_on, got.relay_on);
         check_field("fan_speed", want.fan_speed, got.fan_speed);
         check_field("fan_valid", want.fan_valid, got.fan_valid);
      end
   endtask

   // Request driver: the bus slot frees up on a transaction or while idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_cmd(cmd_on_bus);
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cmd_on_bus.kind;
               req_tdata  <= {2'b00, cmd_on_bus.temp, cmd_on_bus.cell_idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_frame(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic void push_cmd(input logic kind, input logic [5:0] cell_idx,
                                    input logic signed [7:0] temp);
      cell_cmd_type cmd;
      cmd.kind     = kind;
      cmd.cell_idx = cell_idx;
      cmd.temp     = temp;
      pending_cmds.push_back(cmd);
      if (kind == KIND_REPORT || cell_idx < CELL_COUNT) stim_count++;
   endfunction

   function automatic int band_temp();
      return band_lo + $urandom_range(band_hi - band_lo);
   endfunction

   function automatic logic signed [7:0] round_temp();
      if ($urandom_range(3) == 0) return 8'($urandom_range(255));
      return 8'(band_temp());
   endfunction

   function automatic void pick_band();
      int v;
      case ($urandom_range(4))
         0: begin band_lo = -128; band_hi = 127; end
         1: begin band_lo = 15;   band_hi = 50;  end
         2: begin band_lo = 81;   band_hi = 127; end
         3: begin band_lo = -128; band_hi = -30; end
         default: begin
            v = $urandom_range(255) - 128;
            band_lo = v;
            band_hi = v;
         end
      endcase
   endfunction

   // Rewrites every cell from the current band so that later reports see fresh extremes.
   function automatic void fill_table();
      for (int i = 0; i < CELL_COUNT; i++) begin
         push_cmd(KIND_STORE, 6'(i), 8'(band_temp()));
      end
      push_cmd(KIND_REPORT, '0, '0);
   endfunction

   function automatic void queue_directed();
      push_cmd(KIND_REPORT, '0, '0);
      push_cmd(KIND_STORE, 6'd0, 8'sd127);
      push_cmd(KIND_STORE, 6'd59, -8'sd128);
      push_cmd(KIND_STORE, 6'd60, -8'sd100);
      push_cmd(KIND_STORE, 6'd63, -8'sd1);
      push_cmd(KIND_REPORT, '0, '0);
      push_cmd(KIND_STORE, 6'd30, 8'sd127);
      push_cmd(KIND_STORE, 6'd10, -8'sd128);
      push_cmd(KIND_REPORT, '0, '0);
      push_cmd(KIND_STORE, 6'd0, 8'sd40);
      push_cmd(KIND_STORE, 6'd30, 8'sd40);
      push_cmd(KIND_STORE, 6'd10, 8'sd0);
      push_cmd(KIND_STORE, 6'd59, 8'sd0);
      push_cmd(KIND_REPORT, '0, '0);
      push_cmd(KIND_STORE, 6'd0, 8'sd25);
      push_cmd(KIND_STORE, 6'd30, 8'sd25);
      push_cmd(KIND_REPORT, '0, '0);
      push_cmd(KIND_STORE, 6'd0, 8'sd24);
      push_cmd(KIND_STORE, 6'd30, 8'sd24);
      push_cmd(KIND_REPORT, '0, '0);
      push_cmd(KIND_STORE, 6'd5, 8'sd26);
      push_cmd(KIND_STORE, 6'd7, -8'sd3);
      push_cmd(KIND_REPORT, '0, '0);
   endfunction

   task automatic queue_phase(input int budget);
      int n;
      int sel;
      while (stim_count < budget) begin
         sel = $urandom_range(9);
         if (sel < 2) begin
            pick_band();
            fill_table();
         end else if (sel < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) push_cmd(KIND_STORE, 6'($urandom_range(CELL_COUNT - 1)), round_temp());
            push_cmd(KIND_REPORT, '0, '0);
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) push_cmd(1'($urandom_range(1)), 6'($urandom_range(63)),
                                8'($urandom_range(255)));
         end
      end
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0 || req_tvalid || expected_frames.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == REG_MODULE_NUMBER) module_number_q = value;
      else trip_q = value;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_directed();
      drain();

      for (int p = 0; p < 4; p++) begin
         case (p)
            1: begin
               write_reg(REG_MODULE_NUMBER, 8'hFF);
               write_reg(REG_TRIP_TEMPERATURE, 8'h80);
               req_idle_pct  = 88;
               rsp_stall_pct = 0;
            end
            2: begin
               write_reg(REG_MODULE_NUMBER, 8'($urandom_range(255)));
               write_reg(REG_TRIP_TEMPERATURE, 8'h7F);
               req_idle_pct  = 0;
               rsp_stall_pct = 88;
            end
            3: begin
               write_reg(REG_MODULE_NUMBER, 8'h00);
               write_reg(REG_TRIP_TEMPERATURE, 8'($urandom_range(20, 85)));
               req_idle_pct  = 13;
               rsp_stall_pct = 13;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         stim_count = 0;
         // Every cell above the high clamp makes the clamped low exceed the clamped high.
         if (p == 0) begin
            band_lo = 81;
            band_hi = 127;
            fill_table();
         end
         queue_phase(PHASE_ITEMS);
         drain();
      end

      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire
